// ----- design/lpfd_pkg.sv -----
// shared types and codes for the length-prefixed frame deframer
package lpfd_pkg;

   // header layout
   localparam int HEADER_BYTES = 24;
   localparam int COUNT_W      = 5;

   localparam logic [COUNT_W-1:0] POS_VERSION   = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] POS_FLAGS     = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] POS_TYPE      = COUNT_W'(4);
   localparam logic [COUNT_W-1:0] POS_REQUEST   = COUNT_W'(8);
   localparam logic [COUNT_W-1:0] POS_STREAM    = COUNT_W'(16);
   localparam logic [COUNT_W-1:0] POS_LENGTH    = COUNT_W'(20);
   localparam logic [COUNT_W-1:0] POS_LAST      = COUNT_W'(HEADER_BYTES - 1);

   // input item kinds
   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // parser phases
   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_ERROR   = 2'd2;

   // result kinds
   localparam logic [1:0] RK_HEADER  = 2'd0;
   localparam logic [1:0] RK_PAYLOAD = 2'd1;
   localparam logic [1:0] RK_ERROR   = 2'd2;

   // error codes
   localparam logic [1:0] ERR_MAGIC   = 2'd0;
   localparam logic [1:0] ERR_VERSION = 2'd1;
   localparam logic [1:0] ERR_LENGTH  = 2'd2;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERSION = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LEN = 2'd2;

   // one result item
   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  frame_type;
      logic [7:0]  flags;
      logic [63:0] request_tag;
      logic [31:0] stream_tag;
      logic [31:0] frame_len;
      logic [7:0]  payload_byte;
      logic        last;
      logic [1:0]  error_code;
   } rec_type;

   // queue handshake between front and back
   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

// ----- design/lpfd_front.sv -----
// front end: accepts items, collects and checks headers, builds result records
module lpfd_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_accept,
   input  logic                                   in_kind,
   input  logic [7:0]                             in_byte,
   input  logic                                   cfg_we,
   input  logic [lpfd_pkg::CSR_INDEX_W-1:0]       cfg_index,
   input  logic [31:0]                            cfg_data,
   output logic                                   push,
   output lpfd_pkg::rec_type                      rec
);

   logic [1:0]                       phase_ff, phase_in;
   logic [lpfd_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [15:0]                      magic_ff, magic_in;
   logic [7:0]                       version_ff, version_in;
   logic [7:0]                       flags_ff, flags_in;
   logic [7:0]                       type_ff, type_in;
   logic [63:0]                      request_ff, request_in;
   logic [31:0]                      stream_ff, stream_in;
   logic [31:0]                      length_ff, length_in;
   logic [31:0]                      remaining_ff, remaining_in;
   logic [1:0]                       sticky_ff, sticky_in;
   logic [15:0]                      cfg_magic_ff;
   logic [7:0]                       cfg_version_ff;
   logic [31:0]                      cfg_max_ff;
   logic [31:0]                      rem_dec;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_magic_ff   <= '0;
         cfg_version_ff <= '0;
         cfg_max_ff     <= '0;
      end else if (cfg_we) begin
         unique case (cfg_index)
            lpfd_pkg::CSR_MAGIC:   cfg_magic_ff   <= cfg_data[15:0];
            lpfd_pkg::CSR_VERSION: cfg_version_ff <= cfg_data[7:0];
            lpfd_pkg::CSR_MAX_LEN: cfg_max_ff     <= cfg_data;
            default: ;
         endcase
      end
   end

   assign rem_dec = remaining_ff - 32'd1;

   // parser next state and result record
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      magic_in     = magic_ff;
      version_in   = version_ff;
      flags_in     = flags_ff;
      type_in      = type_ff;
      request_in   = request_ff;
      stream_in    = stream_ff;
      length_in    = length_ff;
      remaining_in = remaining_ff;
      sticky_in    = sticky_ff;
      push         = 1'b0;
      rec          = '0;
      if (in_accept) begin
         if (in_kind == lpfd_pkg::KIND_CLEAR) begin
            phase_in     = lpfd_pkg::PH_HEADER;
            count_in     = '0;
            magic_in     = '0;
            version_in   = '0;
            flags_in     = '0;
            type_in      = '0;
            request_in   = '0;
            stream_in    = '0;
            length_in    = '0;
            remaining_in = '0;
            sticky_in    = '0;
         end else begin
            unique case (phase_ff)
               lpfd_pkg::PH_HEADER: begin
                  // shift the byte into its header field
                  if (count_ff < lpfd_pkg::POS_VERSION)
                     magic_in = {magic_ff[7:0], in_byte};
                  else if (count_ff == lpfd_pkg::POS_VERSION)
                     version_in = in_byte;
                  else if (count_ff == lpfd_pkg::POS_FLAGS)
                     flags_in = in_byte;
                  else if (count_ff == lpfd_pkg::POS_TYPE)
                     type_in = in_byte;
                  else if (count_ff < lpfd_pkg::POS_REQUEST) begin
                     // reserved bytes
                  end else if (count_ff < lpfd_pkg::POS_STREAM)
                     request_in = {request_ff[55:0], in_byte};
                  else if (count_ff < lpfd_pkg::POS_LENGTH)
                     stream_in = {stream_ff[23:0], in_byte};
                  else
                     length_in = {length_ff[23:0], in_byte};

                  count_in = count_ff + 1'b1;
                  if (count_ff == lpfd_pkg::POS_LAST) begin
                     // header complete: check magic, version, length
                     count_in = '0;
                     push     = 1'b1;
                     if (magic_in != cfg_magic_ff
                         || version_in != cfg_version_ff
                         || length_in > cfg_max_ff) begin
                        if (magic_in != cfg_magic_ff)
                           sticky_in = lpfd_pkg::ERR_MAGIC;
                        else if (version_in != cfg_version_ff)
                           sticky_in = lpfd_pkg::ERR_VERSION;
                        else
                           sticky_in = lpfd_pkg::ERR_LENGTH;
                        phase_in        = lpfd_pkg::PH_ERROR;
                        rec.result_kind = lpfd_pkg::RK_ERROR;
                        rec.error_code  = sticky_in;
                     end else begin
                        rec.result_kind = lpfd_pkg::RK_HEADER;
                        rec.frame_type  = type_in;
                        rec.flags       = flags_in;
                        rec.request_tag = request_in;
                        rec.stream_tag  = stream_in;
                        rec.frame_len   = length_in;
                        rec.last        = (length_in == 32'd0);
                        remaining_in    = length_in;
                        phase_in        = (length_in == 32'd0) ? lpfd_pkg::PH_HEADER
                                                               : lpfd_pkg::PH_PAYLOAD;
                     end
                  end
               end
               lpfd_pkg::PH_PAYLOAD: begin
                  // pass the byte through, mark the final one
                  push             = 1'b1;
                  remaining_in     = rem_dec;
                  rec.result_kind  = lpfd_pkg::RK_PAYLOAD;
                  rec.frame_type   = type_ff;
                  rec.flags        = flags_ff;
                  rec.request_tag  = request_ff;
                  rec.stream_tag   = stream_ff;
                  rec.frame_len    = length_ff;
                  rec.payload_byte = in_byte;
                  rec.last         = (rem_dec == 32'd0);
                  if (rem_dec == 32'd0) begin
                     phase_in = lpfd_pkg::PH_HEADER;
                     count_in = '0;
                  end
               end
               default: begin
                  // sticky error repeats on every byte
                  push            = 1'b1;
                  rec.result_kind = lpfd_pkg::RK_ERROR;
                  rec.error_code  = sticky_ff;
               end
            endcase
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lpfd_pkg::PH_HEADER;
         count_ff     <= '0;
         magic_ff     <= '0;
         version_ff   <= '0;
         flags_ff     <= '0;
         type_ff      <= '0;
         request_ff   <= '0;
         stream_ff    <= '0;
         length_ff    <= '0;
         remaining_ff <= '0;
         sticky_ff    <= '0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         magic_ff     <= magic_in;
         version_ff   <= version_in;
         flags_ff     <= flags_in;
         type_ff      <= type_in;
         request_ff   <= request_in;
         stream_ff    <= stream_in;
         length_ff    <= length_in;
         remaining_ff <= remaining_in;
         sticky_ff    <= sticky_in;
      end
   end

endmodule

// ----- design/lpfd_queue.sv -----
// two-entry record queue between front and back
module lpfd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lpfd_pkg::rec_type     push_rec,
   input  logic                  pop,
   output lpfd_pkg::rec_type     pop_rec,
   output lpfd_pkg::qstat_type   stat
);

   lpfd_pkg::rec_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] level_ff, level_in;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop)
         level_in = level_ff + 2'd1;
      else if (!push && pop)
         level_in = level_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_rec;
   end

   assign pop_rec    = entry_ff[rd_ptr_ff];
   assign stat.empty = (level_ff == 2'd0);
   assign stat.full  = (level_ff == 2'd2);

endmodule

// ----- design/lpfd_back.sv -----
// back end: output register that drains the queue toward the result channel
module lpfd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  lpfd_pkg::qstat_type   stat,
   input  lpfd_pkg::rec_type     head_rec,
   output logic                  pop,
   input  logic                  out_stall,
   output logic                  out_valid,
   output lpfd_pkg::rec_type     out_rec
);

   logic              valid_ff, valid_in;
   lpfd_pkg::rec_type rec_ff;

   // load when the register is empty or its item is being taken
   assign pop      = !stat.empty && (!valid_ff || !out_stall);
   assign valid_in = pop || (valid_ff && out_stall);

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop)
         rec_ff <= head_rec;
   end

   assign out_valid = valid_ff;
   assign out_rec   = rec_ff;

endmodule

// ----- design/length_prefixed_frame_deframer_unit.sv -----
// top level of the length-prefixed frame deframer
//
// Input channel (req_): one item per accepted cycle, either a stream byte
// or a clear command. Items are accepted when req_valid is high and
// req_stall is low. A clear returns the parser to header collection.
// Result channel (rsp_): a header record after the last of 24 header bytes,
// one record per payload byte (final one with rsp_last), or an error record
// that repeats for every byte until a clear. Taken when rsp_valid is high
// and rsp_stall is low.
// Configuration (csr_): magic, version and payload limit; always ready.
// The user must see it written only while the block is idle; the block
// does not enforce this. Throughput: one item per cycle while req_stall
// is low. A result passes through the queue, written at the accepting
// edge, and then the output register. When the receiver stalls, the
// two-entry queue and output register absorb results; req_stall rises once
// the queue is full, never combinationally from rsp_stall. Reset clears
// parser state, configuration, queue pointers and rsp_valid, not records.
module length_prefixed_frame_deframer_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_kind,
   input  logic [7:0]                         req_data_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_result_kind,
   output logic [7:0]                         rsp_frame_type,
   output logic [7:0]                         rsp_flags,
   output logic [63:0]                        rsp_request_tag,
   output logic [31:0]                        rsp_stream_tag,
   output logic [31:0]                        rsp_frame_len,
   output logic [7:0]                         rsp_payload_byte,
   output logic                               rsp_last,
   output logic [1:0]                         rsp_error_code,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lpfd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                        csr_data
);

   logic                in_accept;
   logic                push;
   logic                pop;
   lpfd_pkg::rec_type   push_rec;
   lpfd_pkg::rec_type   head_rec;
   lpfd_pkg::rec_type   out_rec;
   lpfd_pkg::qstat_type stat;

   assign csr_ready = 1'b1;
   assign req_stall = stat.full;
   assign in_accept = req_valid && !req_stall;

   lpfd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .in_kind   (req_kind),
      .in_byte   (req_data_byte),
      .cfg_we    (csr_valid && csr_ready),
      .cfg_index (csr_index),
      .cfg_data  (csr_data),
      .push      (push),
      .rec       (push_rec)
   );

   lpfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .pop_rec  (head_rec),
      .stat     (stat)
   );

   lpfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .head_rec  (head_rec),
      .pop       (pop),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_rec   (out_rec)
   );

   // result fields
   assign rsp_result_kind  = out_rec.result_kind;
   assign rsp_frame_type   = out_rec.frame_type;
   assign rsp_flags        = out_rec.flags;
   assign rsp_request_tag  = out_rec.request_tag;
   assign rsp_stream_tag   = out_rec.stream_tag;
   assign rsp_frame_len    = out_rec.frame_len;
   assign rsp_payload_byte = out_rec.payload_byte;
   assign rsp_last         = out_rec.last;
   assign rsp_error_code   = out_rec.error_code;

endmodule
